// File: rtl/ipid_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_pkg
// Types, register indexes, mode bits and helpers of the incremental PID block.
// ----------------------------------------------------------------------------
package ipid_pkg;

	localparam int DW = 32;
	localparam int MODE_W = 6;
	localparam int IDX_W = 3;

	localparam logic [IDX_W-1:0] REG_GAIN_P     = 3'd0;
	localparam logic [IDX_W-1:0] REG_GAIN_I     = 3'd1;
	localparam logic [IDX_W-1:0] REG_GAIN_D     = 3'd2;
	localparam logic [IDX_W-1:0] REG_CLAMP_LOW  = 3'd3;
	localparam logic [IDX_W-1:0] REG_CLAMP_HIGH = 3'd4;
	localparam logic [IDX_W-1:0] REG_DEAD_LOW   = 3'd5;
	localparam logic [IDX_W-1:0] REG_DEAD_HIGH  = 3'd6;
	localparam logic [IDX_W-1:0] REG_MODE_FLAGS = 3'd7;

	localparam int MODE_ACC      = 0;
	localparam int MODE_LIMIT    = 1;
	localparam int MODE_MAG_LIM  = 2;
	localparam int MODE_DEAD     = 3;
	localparam int MODE_MAG_DEAD = 4;
	localparam int MODE_HOLD     = 5;

	localparam logic [MODE_W-1:0] MODE_RESET = 6'd1;

	typedef struct packed {
		logic [DW-1:0]     gain_p;
		logic [DW-1:0]     gain_i;
		logic [DW-1:0]     gain_d;
		logic [DW-1:0]     clamp_low;
		logic [DW-1:0]     clamp_high;
		logic [DW-1:0]     dead_low;
		logic [DW-1:0]     dead_high;
		logic [MODE_W-1:0] mode_flags;
	} ipid_cfg_t;

	// error terms handed from the error stage to the multiply stage
	typedef struct packed {
		logic          valid;
		logic          hit;
		logic [DW-1:0] err;
		logic [DW-1:0] diff1;
		logic [DW-1:0] diff2;
	} ipid_diff_t;

	// products handed from the multiply stage to the output stage
	typedef struct packed {
		logic          valid;
		logic          hit;
		logic [DW-1:0] prod_p;
		logic [DW-1:0] prod_i;
		logic [DW-1:0] prod_d;
	} ipid_prod_t;

	// magnitude as an unsigned number; the most negative value maps to 2^(DW-1)
	function automatic logic [DW-1:0] mag(input logic [DW-1:0] x);
		return x[DW-1] ? (~x + 1'b1) : x;
	endfunction

endpackage
`default_nettype wire

// File: rtl/ipid_sample_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_sample_if
// Valid/ready channel carrying one setpoint and measurement sample.
// ----------------------------------------------------------------------------
interface ipid_sample_if import ipid_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [DW-1:0] setpoint;
	logic [DW-1:0] measurement;

	modport source (output valid, output setpoint, output measurement, input ready);
	modport sink   (input valid, input setpoint, input measurement, output ready);
endinterface
`default_nettype wire

// File: rtl/ipid_result_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_result_if
// Valid/ready channel carrying one controller result.
// ----------------------------------------------------------------------------
interface ipid_result_if import ipid_pkg::*; ();
	logic          valid;
	logic          ready;
	logic [DW-1:0] drive;
	logic          in_dead_zone;

	modport source (output valid, output drive, output in_dead_zone, input ready);
	modport sink   (input valid, input drive, input in_dead_zone, output ready);
endinterface
`default_nettype wire

// File: rtl/ipid_err.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_err
// Error forming, error history and dead-zone test.
// ----------------------------------------------------------------------------
module ipid_err import ipid_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire logic          valid_s1,
	input  wire logic [DW-1:0] setpoint_s1,
	input  wire logic [DW-1:0] measurement_s1,
	input  wire ipid_cfg_t     cfg,
	output ipid_diff_t         diff_s2
);

	logic [DW-1:0] err_now_q;
	logic [DW-1:0] err_prev_q;
	logic [DW-1:0] err;
	logic [DW-1:0] diff1;
	logic [DW-1:0] diff2;
	logic [DW-1:0] err_mag;
	logic          hit;
	logic          valid_s2;
	logic          hit_s2;
	logic [DW-1:0] err_s2;
	logic [DW-1:0] diff1_s2;
	logic [DW-1:0] diff2_s2;

	assign err   = setpoint_s1 - measurement_s1;
	assign diff1 = err - err_now_q;
	assign diff2 = err - {err_now_q[DW-2:0], 1'b0} + err_prev_q;
	assign err_mag = mag(err);

	always_comb begin
		hit = 1'b0;
		if (cfg.mode_flags[MODE_DEAD]) begin
			if (cfg.mode_flags[MODE_MAG_DEAD]) begin
				hit = (err_mag >= mag(cfg.dead_low)) && (err_mag <= mag(cfg.dead_high));
			end else begin
				hit = ($signed(err) >= $signed(cfg.dead_low)) &&
				      ($signed(err) <= $signed(cfg.dead_high));
			end
		end
	end

	// history shifts on every sample, dead zone or not
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_now_q  <= '0;
			err_prev_q <= '0;
			valid_s2   <= 1'b0;
		end else if (en) begin
			valid_s2 <= valid_s1;
			if (valid_s1) begin
				err_now_q  <= err;
				err_prev_q <= err_now_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hit_s2   <= hit;
			err_s2   <= err;
			diff1_s2 <= diff1;
			diff2_s2 <= diff2;
		end
	end

	assign diff_s2 = '{valid: valid_s2, hit: hit_s2, err: err_s2,
	                   diff1: diff1_s2, diff2: diff2_s2};

endmodule
`default_nettype wire

// File: rtl/ipid_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_mul
// Three parallel gain multiplies, low word kept, registered.
// ----------------------------------------------------------------------------
module ipid_mul import ipid_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       en,
	input  wire ipid_diff_t diff_s2,
	input  wire ipid_cfg_t  cfg,
	output ipid_prod_t      prod_s3
);

	logic          valid_s3;
	logic          hit_s3;
	logic [DW-1:0] prod_p_s3;
	logic [DW-1:0] prod_i_s3;
	logic [DW-1:0] prod_d_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s3 <= diff_s2.valid;
		end
	end

	// low word of a product is the same for signed and unsigned operands
	always_ff @(posedge clk) begin
		if (en) begin
			hit_s3    <= diff_s2.hit;
			prod_p_s3 <= DW'(cfg.gain_p * diff_s2.diff1);
			prod_i_s3 <= DW'(cfg.gain_i * diff_s2.err);
			prod_d_s3 <= DW'(cfg.gain_d * diff_s2.diff2);
		end
	end

	assign prod_s3 = '{valid: valid_s3, hit: hit_s3, prod_p: prod_p_s3,
	                   prod_i: prod_i_s3, prod_d: prod_d_s3};

endmodule
`default_nettype wire

// File: rtl/ipid_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ipid_out
// Increment sum, accumulate, output limit and result register.
// ----------------------------------------------------------------------------
module ipid_out import ipid_pkg::*; (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          en,
	input  wire ipid_prod_t    prod_s3,
	input  wire ipid_cfg_t     cfg,
	output logic               result_valid_q,
	output logic [DW-1:0]      drive_q,
	output logic               dead_q
);

	logic [DW-1:0] acc_q;
	logic [DW-1:0] incr;
	logic [DW-1:0] raw;
	logic [DW-1:0] lim;
	logic [DW-1:0] raw_mag;
	logic          positive;
	logic          take;

	assign take = en && prod_s3.valid;
	assign incr = prod_s3.prod_p + prod_s3.prod_i + prod_s3.prod_d;
	assign raw  = cfg.mode_flags[MODE_ACC] ? (acc_q + incr) : incr;
	assign raw_mag  = mag(raw);
	assign positive = !raw[DW-1] && (raw != '0);

	always_comb begin
		lim = raw;
		if (cfg.mode_flags[MODE_LIMIT]) begin
			if (cfg.mode_flags[MODE_MAG_LIM]) begin
				// zero counts as negative here
				if (raw_mag < mag(cfg.clamp_low)) begin
					lim = positive ? cfg.clamp_low : (~cfg.clamp_low + 1'b1);
				end else if (raw_mag > mag(cfg.clamp_high)) begin
					lim = positive ? cfg.clamp_high : (~cfg.clamp_high + 1'b1);
				end
			end else begin
				if ($signed(raw) < $signed(cfg.clamp_low)) begin
					lim = cfg.clamp_low;
				end else if ($signed(raw) > $signed(cfg.clamp_high)) begin
					lim = cfg.clamp_high;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q          <= '0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			result_valid_q <= prod_s3.valid;
			// dead-zone hit leaves the accumulator alone
			if (take && !prod_s3.hit) begin
				acc_q <= lim;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			dead_q <= prod_s3.hit;
			if (prod_s3.hit) begin
				drive_q <= cfg.mode_flags[MODE_HOLD] ? acc_q : '0;
			end else begin
				drive_q <= lim;
			end
		end
	end

	a_hit_keeps_acc: assert property (@(posedge clk) disable iff (!arst_n)
		take && prod_s3.hit |=> $stable(acc_q))
		else $error("accumulator changed on dead-zone hit");

	a_hit_zero_drive: assert property (@(posedge clk) disable iff (!arst_n)
		take && prod_s3.hit && !cfg.mode_flags[MODE_HOLD] |=> drive_q == '0 && dead_q)
		else $error("dead-zone hit without hold must drive zero");

	a_result_to_acc: assert property (@(posedge clk) disable iff (!arst_n)
		take && !prod_s3.hit |=> acc_q == drive_q && !dead_q)
		else $error("accumulator and result disagree");

	a_signed_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		take && !prod_s3.hit && cfg.mode_flags[MODE_LIMIT] &&
		!cfg.mode_flags[MODE_MAG_LIM] &&
		($signed(cfg.clamp_low) <= $signed(cfg.clamp_high))
		|=> ($signed(drive_q) >= $signed(cfg.clamp_low)) &&
		    ($signed(drive_q) <= $signed(cfg.clamp_high)))
		else $error("signed limit violated");

endmodule
`default_nettype wire

// File: rtl/incremental_pid_deadzone_limit_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// incremental_pid_deadzone_limit_top
// Velocity-form PID with dead zone and signed or magnitude output limit.
// ----------------------------------------------------------------------------
// Pipeline: input register, error stage, multiply stage, result register.
// Throughput: one sample per cycle while no result is held; the accumulator
//   loop closes through its own register.
// A held result stalls all stages together until it is taken.
// Reset clears error history, accumulator and stage valids; registers return
//   to zero, mode_flags to accumulate only.
module incremental_pid_deadzone_limit_top import ipid_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             write_en,
	input  wire logic [IDX_W-1:0] write_index,
	input  wire logic [DW-1:0]    write_data,
	ipid_sample_if.sink           sample,
	ipid_result_if.source         result
);

	ipid_cfg_t     cfg_q;
	logic          en;
	logic          valid_s1;
	logic [DW-1:0] setpoint_s1;
	logic [DW-1:0] measurement_s1;
	ipid_diff_t    diff_s2;
	ipid_prod_t    prod_s3;
	logic          result_valid_q;
	logic [DW-1:0] drive_q;
	logic          dead_q;

	// advance everything unless a result is waiting to be taken
	assign en           = !result_valid_q || result.ready;
	assign sample.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '{gain_p: '0, gain_i: '0, gain_d: '0,
			           clamp_low: '0, clamp_high: '0,
			           dead_low: '0, dead_high: '0,
			           mode_flags: MODE_RESET};
		end else if (write_en) begin
			case (write_index)
				REG_GAIN_P:     cfg_q.gain_p     <= write_data;
				REG_GAIN_I:     cfg_q.gain_i     <= write_data;
				REG_GAIN_D:     cfg_q.gain_d     <= write_data;
				REG_CLAMP_LOW:  cfg_q.clamp_low  <= write_data;
				REG_CLAMP_HIGH: cfg_q.clamp_high <= write_data;
				REG_DEAD_LOW:   cfg_q.dead_low   <= write_data;
				REG_DEAD_HIGH:  cfg_q.dead_high  <= write_data;
				REG_MODE_FLAGS: cfg_q.mode_flags <= write_data[MODE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en && sample.valid) begin
			setpoint_s1    <= sample.setpoint;
			measurement_s1 <= sample.measurement;
		end
	end

	ipid_err u_err (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.valid_s1       (valid_s1),
		.setpoint_s1    (setpoint_s1),
		.measurement_s1 (measurement_s1),
		.cfg            (cfg_q),
		.diff_s2        (diff_s2)
	);

	ipid_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.diff_s2 (diff_s2),
		.cfg     (cfg_q),
		.prod_s3 (prod_s3)
	);

	ipid_out u_out (
		.clk            (clk),
		.arst_n         (arst_n),
		.en             (en),
		.prod_s3        (prod_s3),
		.cfg            (cfg_q),
		.result_valid_q (result_valid_q),
		.drive_q        (drive_q),
		.dead_q         (dead_q)
	);

	assign result.valid        = result_valid_q;
	assign result.drive        = drive_q;
	assign result.in_dead_zone = dead_q;

endmodule
`default_nettype wire

// File: sim/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the incremental PID with dead zone and output limit.
// A clocked driver feeds setpoint/measurement transfers from a queue, a
// clocked monitor predicts each result from its own copy of the error
// history, accumulator and registers, and compares every result transfer.
// Directed settings cover extreme values, dead-zone hits and the magnitude
// limit corners; random register settings and samples follow.
// ----------------------------------------------------------------------------
module tb_top;
	import ipid_pkg::*;

	localparam int CYCLE_LIMIT = 100000;

	localparam logic [MODE_W-1:0] F_ACC      = 1 << MODE_ACC;
	localparam logic [MODE_W-1:0] F_LIMIT    = 1 << MODE_LIMIT;
	localparam logic [MODE_W-1:0] F_MAG_LIM  = 1 << MODE_MAG_LIM;
	localparam logic [MODE_W-1:0] F_DEAD     = 1 << MODE_DEAD;
	localparam logic [MODE_W-1:0] F_MAG_DEAD = 1 << MODE_MAG_DEAD;
	localparam logic [MODE_W-1:0] F_HOLD     = 1 << MODE_HOLD;

	typedef struct packed {
		logic [DW-1:0] setpoint;
		logic [DW-1:0] measurement;
	} sample_t;

	typedef struct packed {
		logic [DW-1:0] drive;
		logic          in_dead_zone;
	} drive_t;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             write_en;
	logic [IDX_W-1:0] write_index;
	logic [DW-1:0]    write_data;

	ipid_sample_if sample_ch ();
	ipid_result_if result_ch ();

	incremental_pid_deadzone_limit_top i_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.write_en    (write_en),
		.write_index (write_index),
		.write_data  (write_data),
		.sample      (sample_ch),
		.result      (result_ch)
	);

	// bench copy of the registers and of the controller state
	ipid_cfg_t     regs;
	logic [DW-1:0] err_now, err_prev, err_prev2, drive_acc;

	sample_t setpoint_queue [$];
	drive_t  predicted_drive [$];

	logic sample_taken = 1'b0;
	logic steady = 1'b0;
	int   mismatch_count = 0;
	int   cycle_count = 0;

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	function automatic logic [DW-1:0] abs_u(input logic [DW-1:0] x);
		return x[DW-1] ? (0 - x) : x;
	endfunction

	task automatic pid_step(input sample_t s);
		logic [DW-1:0] e, incr, outv, lo_mag, hi_mag;
		logic          hit, positive;
		drive_t        res;
		e = s.setpoint - s.measurement;
		err_prev2 = err_prev;
		err_prev  = err_now;
		err_now   = e;
		hit = 1'b0;
		if (regs.mode_flags[MODE_DEAD]) begin
			if (regs.mode_flags[MODE_MAG_DEAD])
				hit = abs_u(e) >= abs_u(regs.dead_low) && abs_u(e) <= abs_u(regs.dead_high);
			else
				hit = $signed(e) >= $signed(regs.dead_low) && $signed(e) <= $signed(regs.dead_high);
		end
		if (hit) begin
			// accumulator stays untouched inside the dead zone
			res.drive = regs.mode_flags[MODE_HOLD] ? drive_acc : '0;
			res.in_dead_zone = 1'b1;
		end else begin
			incr = regs.gain_p * (e - err_prev) + regs.gain_i * e
				+ regs.gain_d * (e - (err_prev << 1) + err_prev2);
			outv = regs.mode_flags[MODE_ACC] ? drive_acc + incr : incr;
			if (regs.mode_flags[MODE_LIMIT]) begin
				if (regs.mode_flags[MODE_MAG_LIM]) begin
					// zero counts as negative here
					positive = !outv[DW-1] && outv != '0;
					lo_mag = abs_u(regs.clamp_low);
					hi_mag = abs_u(regs.clamp_high);
					if (abs_u(outv) < lo_mag)
						outv = positive ? regs.clamp_low : 0 - regs.clamp_low;
					else if (abs_u(outv) > hi_mag)
						outv = positive ? regs.clamp_high : 0 - regs.clamp_high;
				end else begin
					if ($signed(outv) < $signed(regs.clamp_low))
						outv = regs.clamp_low;
					else if ($signed(regs.clamp_high) < $signed(outv))
						outv = regs.clamp_high;
				end
			end
			drive_acc = outv;
			res.drive = outv;
			res.in_dead_zone = 1'b0;
		end
		predicted_drive.push_back(res);
	endtask

	// inputs change on the falling edge
	always @(negedge clk) begin : drive_samples
		sample_t item;
		if (!arst_n) begin
			sample_ch.valid <= 1'b0;
			result_ch.ready <= 1'b0;
		end else begin
			result_ch.ready <= steady || ($urandom_range(99) >= 21);
			if (!sample_ch.valid || sample_taken) begin
				if (setpoint_queue.size() != 0 && (steady || $urandom_range(99) >= 21)) begin
					item = setpoint_queue.pop_front();
					sample_ch.setpoint    <= item.setpoint;
					sample_ch.measurement <= item.measurement;
					sample_ch.valid       <= 1'b1;
				end else begin
					sample_ch.valid <= 1'b0;
				end
			end
		end
	end

	// check results first, then predict from the sample taken at this edge
	always @(posedge clk) begin : watch_transfers
		drive_t want;
		sample_taken <= arst_n && sample_ch.valid && sample_ch.ready;
		if (arst_n && result_ch.valid && result_ch.ready) begin
			if (predicted_drive.size() == 0) begin
				$display("%0t unexpected result: drive %h in_dead_zone %b", $time,
					result_ch.drive, result_ch.in_dead_zone);
				mismatch_count++;
			end else begin
				want = predicted_drive.pop_front();
				if (result_ch.drive !== want.drive) begin
					$display("%0t drive: expected %h, actual %h", $time,
						want.drive, result_ch.drive);
					mismatch_count++;
				end
				if (result_ch.in_dead_zone !== want.in_dead_zone) begin
					$display("%0t in_dead_zone: expected %b, actual %b", $time,
						want.in_dead_zone, result_ch.in_dead_zone);
					mismatch_count++;
				end
			end
		end
		if (arst_n && sample_ch.valid && sample_ch.ready)
			pid_step({sample_ch.setpoint, sample_ch.measurement});
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DW-1:0] data);
		@(negedge clk);
		write_en    <= 1'b1;
		write_index <= idx;
		write_data  <= data;
		case (idx)
			REG_GAIN_P:     regs.gain_p = data;
			REG_GAIN_I:     regs.gain_i = data;
			REG_GAIN_D:     regs.gain_d = data;
			REG_CLAMP_LOW:  regs.clamp_low = data;
			REG_CLAMP_HIGH: regs.clamp_high = data;
			REG_DEAD_LOW:   regs.dead_low = data;
			REG_DEAD_HIGH:  regs.dead_high = data;
			REG_MODE_FLAGS: regs.mode_flags = data[MODE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic program_regs(input logic [DW-1:0] gp, gi, gd, cl, ch, dl, dh, mode);
		write_reg(REG_GAIN_P, gp);
		write_reg(REG_GAIN_I, gi);
		write_reg(REG_GAIN_D, gd);
		write_reg(REG_CLAMP_LOW, cl);
		write_reg(REG_CLAMP_HIGH, ch);
		write_reg(REG_DEAD_LOW, dl);
		write_reg(REG_DEAD_HIGH, dh);
		write_reg(REG_MODE_FLAGS, mode);
		@(negedge clk);
		write_en <= 1'b0;
	endtask

	task automatic push_sample(input logic [DW-1:0] sp, input logic [DW-1:0] pv);
		setpoint_queue.push_back({sp, pv});
	endtask

	// hold until every queued sample is taken and every result has come back
	task automatic wait_drained();
		while (setpoint_queue.size() != 0 || sample_ch.valid || predicted_drive.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	function automatic logic [DW-1:0] rand_word(input int span);
		int r;
		r = $urandom_range(99);
		if (r < 8) begin
			case ($urandom_range(4))
				0: return 32'h8000_0000;
				1: return 32'h7FFF_FFFF;
				2: return '0;
				3: return '1;
				default: return 32'd1;
			endcase
		end
		if (r < 20)
			return $urandom;
		return int'($urandom_range(2 * span)) - span;
	endfunction

	initial begin : stimulus
		logic [DW-1:0] lo, hi, dlo, dhi, tmp;
		int            n_items;
		arst_n             = 1'b0;
		write_en           = 1'b0;
		write_index        = '0;
		write_data         = '0;
		sample_ch.valid       = 1'b0;
		sample_ch.setpoint    = '0;
		sample_ch.measurement = '0;
		result_ch.ready       = 1'b0;
		regs = '0;
		regs.mode_flags = MODE_RESET;
		err_now = '0;
		err_prev = '0;
		err_prev2 = '0;
		drive_acc = '0;
		repeat (9) @(negedge clk);
		arst_n <= 1'b1;

		// reset settings, extreme inputs
		push_sample(32'h0, 32'h0);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000);
		push_sample(32'h8000_0000, 32'h0);
		push_sample(32'h0, 32'h8000_0000);
		wait_drained();

		// accumulate with a signed limit
		program_regs(3, 1, -2, -1000, 1000, 0, 0, F_ACC | F_LIMIT);
		push_sample(10, 0);
		push_sample(500, 0);
		push_sample(-700, 0);
		push_sample(32'hFFFF_FFFF, 32'h7FFF_FFFF);
		wait_drained();

		// signed dead zone, hold the accumulator, edges inclusive
		program_regs(1, 1, 1, 0, 0, -5, 5, F_ACC | F_DEAD | F_HOLD);
		push_sample(6, 0);
		push_sample(0, 0);
		push_sample(-5, 0);
		push_sample(5, 0);
		push_sample(-6, 0);
		wait_drained();

		// magnitude dead zone reaching the most negative error
		program_regs(1, 2, 0, 0, 0, 3, 32'h8000_0000, F_DEAD | F_MAG_DEAD);
		push_sample(32'h8000_0000, 0);
		push_sample(2, 0);
		push_sample(-3, 0);
		wait_drained();

		// magnitude limit: zero output is treated as negative
		program_regs(0, 1, 0, 7, 100, 0, 0, F_LIMIT | F_MAG_LIM);
		push_sample(0, 0);
		push_sample(3, 0);
		push_sample(-200, 0);
		push_sample(32'h8000_0000, 0);
		wait_drained();

		// magnitude limit with negative bounds
		program_regs(0, 1, 0, -7, -100, 0, 0, F_LIMIT | F_MAG_LIM);
		push_sample(3, 0);
		push_sample(-200, 0);
		wait_drained();

		// inverted bounds on both the clamp and the dead zone
		program_regs(0, 1, 0, 50, -50, 10, -10, F_LIMIT | F_DEAD);
		push_sample(0, 0);
		push_sample(100, 0);
		wait_drained();

		// extreme gains, wrapping products
		program_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 0, 0, 0, 0, F_ACC);
		push_sample(32'h7FFF_FFFF, 32'h8000_0000);
		push_sample(32'h8000_0000, 32'h7FFF_FFFF);
		wait_drained();

		for (int ph = 0; ph < 12; ph++) begin
			steady = (ph == 5);
			n_items = steady ? 80 : 38;
			lo = rand_word(400);
			hi = rand_word(400);
			if ($urandom_range(3) != 0 && $signed(lo) > $signed(hi)) begin
				tmp = lo;
				lo = hi;
				hi = tmp;
			end
			dlo = rand_word(20);
			dhi = rand_word(20);
			if ($urandom_range(3) != 0 && $signed(dlo) > $signed(dhi)) begin
				tmp = dlo;
				dlo = dhi;
				dhi = tmp;
			end
			program_regs(rand_word(8), rand_word(8), rand_word(8), lo, hi, dlo, dhi, $urandom);
			repeat (n_items) push_sample(rand_word(60), rand_word(60));
			wait_drained();
		end
		steady = 1'b0;

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire

// File: sim.f
rtl/ipid_pkg.sv
rtl/ipid_sample_if.sv
rtl/ipid_result_if.sv
rtl/ipid_err.sv
rtl/ipid_mul.sv
rtl/ipid_out.sv
rtl/incremental_pid_deadzone_limit_top.sv
sim/tb_top.sv
